@@ sv/sha256_pkg.sv @@
// Package with the SHA-256 constants, types and round functions shared by the digest unit.
`default_nettype none
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    BYTE_DATA,
    BYTE_PAD,
    BYTE_ZERO,
    BYTE_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      clear_all;
    logic      write_byte;
    byte_sel_t byte_sel;
    logic [5:0] byte_addr;
    logic      count_bits;
    logic      load_work;
    logic      do_round;
    logic [5:0] round_idx;
    logic      fold;
    logic      emit;
    logic [2:0] emit_idx;
  } dp_cmd_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

endpackage
`default_nettype wire

@@ sv/sha256_ctrl.sv @@
// Controller state machine sequencing absorb, padding, rounds and digest output.
`default_nettype none
module sha256_ctrl
  import sha256_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic       opcode,
  output logic            busy,
  output dp_cmd_t         cmd
);

  state_t state, state_next;
  logic [5:0] fill, fill_next;
  logic [5:0] cnt, cnt_next;
  logic       final_blk, final_blk_next;
  logic       accept;

  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    fill_next = fill;
    cnt_next = cnt;
    final_blk_next = final_blk;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!opcode) begin
            fill_next = fill + 6'd1;
            if (fill == 6'd63) begin
              state_next = ST_ROUND;
              final_blk_next = 1'b0;
              cnt_next = '0;
            end
          end else begin
            if (fill == 6'd63) begin
              state_next = ST_ROUND;
            end else begin
              state_next = ST_PAD;
            end
            cnt_next = fill + 6'd1;
            final_blk_next = (fill < 6'd56);
          end
        end
      end
      ST_PAD: begin
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd63) begin
          state_next = ST_ROUND;
          cnt_next = '0;
        end
      end
      ST_ROUND: begin
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd63) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cnt_next = '0;
        fill_next = '0;
        if (!final_blk) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd7) begin
          state_next = ST_IDLE;
          final_blk_next = 1'b0;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    // A second padding block follows when the first held no room for the length.
    if (state == ST_FOLD && !final_blk && fill != 6'd0) begin
      state_next = ST_PAD;
      final_blk_next = 1'b1;
      cnt_next = '0;
      fill_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill <= '0;
      cnt <= '0;
      final_blk <= 1'b0;
    end else begin
      state <= state_next;
      fill <= fill_next;
      cnt <= cnt_next;
      final_blk <= final_blk_next;
    end
  end

  always_comb begin
    busy = (state != ST_IDLE);
    cmd = '0;
    cmd.byte_sel = BYTE_DATA;
    cmd.byte_addr = fill;
    cmd.round_idx = cnt;
    cmd.emit_idx = cnt[2:0];
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.write_byte = 1'b1;
          cmd.load_work = (fill == 6'd63);
          if (!opcode) begin
            cmd.count_bits = 1'b1;
          end else begin
            cmd.byte_sel = BYTE_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.write_byte = 1'b1;
        cmd.byte_addr = cnt;
        if (final_blk && cnt >= LEN_POS) begin
          cmd.byte_sel = BYTE_LEN;
        end else begin
          cmd.byte_sel = BYTE_ZERO;
        end
        cmd.load_work = (cnt == 6'd63);
      end
      ST_ROUND: cmd.do_round = 1'b1;
      ST_FOLD: cmd.fold = 1'b1;
      ST_EMIT: begin
        cmd.emit = 1'b1;
        cmd.clear_all = (cnt == 6'd7);
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/sha256_dp.sv @@
// Datapath holding the block buffer, bit counter, chaining value and one-round compression unit.
`default_nettype none
module sha256_dp
  import sha256_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  data_byte,
  input  dp_cmd_t          cmd,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last,
  output logic             done
);

  logic [31:0] buffer [16];
  logic [63:0] message_bits;
  logic [31:0] hv [8];
  logic [31:0] r [8];
  logic [31:0] w [16];
  logic [7:0]  wr_byte;
  logic [31:0] big0, big1, ch, mj, t1, t2, wt, s0, s1, wnew;

  always_comb begin
    case (cmd.byte_sel)
      BYTE_DATA: wr_byte = data_byte;
      BYTE_PAD:  wr_byte = PAD_BYTE;
      BYTE_ZERO: wr_byte = 8'h00;
      BYTE_LEN:  wr_byte = message_bits[8 * (7 - cmd.byte_addr[2:0]) +: 8];
      default:   wr_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.write_byte) begin
      buffer[cmd.byte_addr[5:2]][8 * (3 - cmd.byte_addr[1:0]) +: 8] <= wr_byte;
    end
  end

  always_comb begin
    wt = (cmd.round_idx < 6'd16) ? w[cmd.round_idx[3:0]] : wnew;
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    wnew = w[0] + s0 + w[9] + s1;
    big1 = rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25);
    ch = (r[4] & r[5]) ^ (~r[4] & r[6]);
    t1 = r[7] + big1 + ch + ROUND_K[cmd.round_idx] + wt;
    big0 = rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22);
    mj = (r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]);
    t2 = big0 + mj;
  end

  // The schedule window is loaded from the buffer, then shifts once per round from round 16 on.
  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      for (int i = 0; i < 16; i++) begin
        if (i == 15) begin
          w[i] <= {buffer[15][31:8], wr_byte};
        end else begin
          w[i] <= buffer[i];
        end
      end
      for (int i = 0; i < 8; i++) begin
        r[i] <= hv[i];
      end
    end else if (cmd.do_round) begin
      if (cmd.round_idx >= 6'd16) begin
        for (int i = 0; i < 15; i++) begin
          w[i] <= w[i+1];
        end
        w[15] <= wnew;
      end
      r[7] <= r[6];
      r[6] <= r[5];
      r[5] <= r[4];
      r[4] <= r[3] + t1;
      r[3] <= r[2];
      r[2] <= r[1];
      r[1] <= r[0];
      r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      message_bits <= '0;
      for (int i = 0; i < 8; i++) hv[i] <= IV[i];
    end else begin
      if (cmd.count_bits) begin
        message_bits <= message_bits + 64'd8;
      end
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) hv[i] <= hv[i] + r[i];
      end
      if (cmd.clear_all) begin
        message_bits <= '0;
        for (int i = 0; i < 8; i++) hv[i] <= IV[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      last <= 1'b0;
    end else begin
      done <= cmd.emit;
      last <= cmd.emit && (cmd.emit_idx == 3'd7);
    end
    digest_word <= hv[cmd.emit_idx];
    word_index <= cmd.emit_idx;
  end

endmodule
`default_nettype wire

@@ sv/sha256_message_digest_unit.sv @@
// Top level of the SHA-256 message digest unit.
// Usage: raise start with opcode and data_byte; a transaction is taken when
// start is high and busy is low. Opcode 0 absorbs one byte; opcode 1 pads
// the message and returns the digest.
// An absorb leaves busy low, except the sixty-fourth byte of a block,
// after which busy stays high while the round unit performs
// one round per cycle and then adds into the chaining value.
// A finish writes the remaining padding one byte per cycle, compresses
// the block and possibly a second padded block, then presents the eight
// digest words on consecutive cycles, each marked by done for one cycle,
// word_index counting up and last high on the eighth.
// The time until the last word depends on the block fill and on
// whether a second block is needed.
// The result strobe cannot be held off by the receiver; words must be
// taken in the cycle they appear.
// After the last word the unit is ready for a new message. Reset restores
// the initial hash value and clears the bit counter and fill.
`default_nettype none
module sha256_message_digest_unit
  import sha256_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic        opcode,
  input  wire logic [7:0]  data_byte,
  output logic             busy,
  output logic             done,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last
);

  dp_cmd_t cmd;

  sha256_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .busy   (busy),
    .cmd    (cmd)
  );

  sha256_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .cmd         (cmd),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last        (last),
    .done        (done)
  );

  a_last_only_with_done: assert property (@(posedge clk) disable iff (rst)
    last |-> done) else $error("last without done");
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    last |-> (word_index == 3'd7)) else $error("last on wrong word");
  a_busy_while_emit: assert property (@(posedge clk) disable iff (rst)
    done && !last |-> busy) else $error("unit idle during digest output");

endmodule
`default_nettype wire

@@ sim/tb_sha256_message_digest_unit.sv @@
// Self-checking testbench for the SHA-256 message digest unit with its own digest predictor.
`default_nettype none
module tb_sha256_message_digest_unit;
  import sha256_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        is_last;
  } digest_entry_t;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;
  localparam int ITEM_TARGET = 410;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic opcode = OP_ABSORB;
  logic [7:0] data_byte = 8'h00;
  logic busy, done, last;
  logic [31:0] digest_word;
  logic [2:0] word_index;

  logic [31:0] hash_state [8];
  logic [7:0]  msg_block [64];
  int unsigned msg_fill;
  logic [63:0] msg_bits;
  digest_entry_t digest_queue [$];

  int errors = 0;
  int items_sent = 0;
  int digests_seen = 0;
  int sender_idle_pct = 0;

  sha256_message_digest_unit dut (
    .clk(clk), .rst(rst), .start(start), .opcode(opcode), .data_byte(data_byte),
    .busy(busy), .done(done), .digest_word(digest_word), .word_index(word_index),
    .last(last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress_msg_block();
    logic [31:0] w [64];
    logic [31:0] r [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) begin
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) r[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = r[7] + (ror32(r[4], 6) ^ ror32(r[4], 11) ^ ror32(r[4], 25))
           + ((r[4] & r[5]) ^ (~r[4] & r[6])) + ROUND_K[i] + w[i];
      t2 = (ror32(r[0], 2) ^ ror32(r[0], 13) ^ ror32(r[0], 22))
           + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
      r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + r[i];
  endtask

  task automatic restart_message();
    for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
    msg_fill = 0;
    msg_bits = '0;
  endtask

  task automatic predict_digest(input logic op, input logic [7:0] b);
    int unsigned pos;
    digest_entry_t e;
    if (op == OP_ABSORB) begin
      msg_block[msg_fill] = b;
      msg_fill++;
      msg_bits = msg_bits + 64'd8;
      if (msg_fill == 64) begin
        compress_msg_block();
        msg_fill = 0;
      end
    end else begin
      pos = msg_fill;
      msg_block[pos] = PAD_BYTE;
      pos++;
      if (pos > LEN_POS) begin
        while (pos < 64) msg_block[pos++] = 8'h00;
        compress_msg_block();
        pos = 0;
      end
      while (pos < LEN_POS) msg_block[pos++] = 8'h00;
      for (int k = 0; k < 8; k++) msg_block[63-k] = msg_bits[8*k +: 8];
      compress_msg_block();
      for (int k = 0; k < 8; k++) begin
        e.word = hash_state[k];
        e.index = 3'(k);
        e.is_last = (k == 7);
        digest_queue = {digest_queue, e};
      end
      restart_message();
    end
  endtask

  task automatic send_item(input logic op, input logic [7:0] b);
    start <= 1'b1;
    opcode <= op;
    data_byte <= b;
    do @(posedge clk); while (busy);
    predict_digest(op, b);
    items_sent++;
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_item(OP_ABSORB, 8'($urandom_range(255)));
    send_item(OP_FINISH, 8'($urandom_range(255)));
  endtask

  always @(posedge clk) begin
    digest_entry_t e;
    if (!rst && done) begin
      if (digest_queue.size() == 0) begin
        $error("digest word with no transaction pending: %h", digest_word);
        errors++;
      end else begin
        e = digest_queue.pop_front();
        digests_seen++;
        if (digest_word !== e.word) begin
          $error("digest_word expected %h actual %h", e.word, digest_word);
          errors++;
        end
        if (word_index !== e.index) begin
          $error("word_index expected %0d actual %0d", e.index, word_index);
          errors++;
        end
        if (last !== e.is_last) begin
          $error("last expected %0b actual %0b", e.is_last, last);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    sender_idle_pct = 0;
    send_item(OP_FINISH, 8'hff);
    send_item(OP_FINISH, 8'h00);
    send_item(OP_ABSORB, 8'h00);
    send_item(OP_FINISH, 8'h00);
    send_item(OP_ABSORB, 8'hff);
    send_item(OP_FINISH, 8'hff);
    send_item(OP_ABSORB, 8'h61);
    send_item(OP_ABSORB, 8'h62);
    send_item(OP_ABSORB, 8'h63);
    send_item(OP_FINISH, 8'h00);
  endtask

  task automatic test_random(input int idle_pct, input int item_goal);
    int len;
    sender_idle_pct = idle_pct;
    while (items_sent < item_goal) begin
      case ($urandom_range(5))
        0: len = 55 + $urandom_range(1);
        1: len = 63 + $urandom_range(1);
        2: len = $urandom_range(3);
        default: len = $urandom_range(80);
      endcase
      if (items_sent + len + 1 > item_goal) len = item_goal - items_sent - 1;
      send_message(len);
    end
  endtask

  initial begin
    int wait_cycles;
    restart_message();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(0, 140);
    test_random(55, 280);
    test_random(29, ITEM_TARGET);
    start <= 1'b0;
    wait_cycles = 0;
    while (digest_queue.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (250) @(posedge clk);
    if (digest_queue.size() != 0) begin
      $error("%0d digest words never arrived", digest_queue.size());
      errors++;
    end
    $display("Sent %0d transactions and checked %0d digest words,", items_sent, digests_seen);
    $display("covering empty, short and block-boundary messages under sender idling.");
    if (errors == 0) begin
      $display("PASS sha256_message_digest_unit");
    end else begin
      $display("FAIL sha256_message_digest_unit");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("FAIL sha256_message_digest_unit");
    $finish;
  end
endmodule
`default_nettype wire
